### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL of the score tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clk out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// tkst_pkg
// Sizes, codes and types shared by the cells and the top level of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

    localparam int LIST_LEN   = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
    localparam int COORD_W    = 3 * COORD_BITS;

    localparam int SCORE_W    = 32;
    localparam int FIELD_W    = 16;
    localparam int RRANK_W    = 6;
    localparam int TRANK_W    = 7;
    localparam int OP_W       = 2;
    localparam int DATA_W     = 88;

    localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic REG_KEEP_SMALLEST = 1'b0;
    localparam logic REG_FILL_SCORE    = 1'b1;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [COORD_W-1:0]        coord_t;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic   offer;
        logic   clear;
        logic   keep_smallest;
        score_t fill_score;
        score_t cand_score;
        coord_t cand_coord;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/tkst_cell.sv
// ----------------------------------------------------------------------------
// tkst_cell
// One entry of the sorted list: compare against the offered score, shift in
// from the left neighbor, take the candidate, load the fill value, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tkst_pkg::cell_cmd_t  cmd,
    input  wire logic                 hit_in,
    input  wire tkst_pkg::score_t     prev_score,
    input  wire tkst_pkg::coord_t     prev_coord,
    output logic                      hit_out,
    output logic                      first_hit,
    output tkst_pkg::score_t          score,
    output tkst_pkg::coord_t          coord
);

    tkst_pkg::score_t score_reg;
    tkst_pkg::score_t score_next;
    tkst_pkg::coord_t coord_reg;
    tkst_pkg::coord_t coord_next;
    logic             beats;

    always_comb
    begin
        beats = cmd.keep_smallest ? (cmd.cand_score < score_reg)
                                  : (cmd.cand_score > score_reg);
    end

    assign hit_out   = hit_in | beats;
    assign first_hit = beats & ~hit_in;

    always_comb
    begin
        score_next = score_reg;
        coord_next = coord_reg;
        priority if (cmd.clear)
        begin
            score_next = cmd.fill_score;
            coord_next = '0;
        end
        else if (cmd.offer && hit_in)
        begin
            // an earlier entry took the candidate: shift down one place
            score_next = prev_score;
            coord_next = prev_coord;
        end
        else if (cmd.offer && beats)
        begin
            score_next = cmd.cand_score;
            coord_next = cmd.cand_coord;
        end
        else
        begin
            // hold the entry
            score_next = score_reg;
            coord_next = coord_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            coord_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
            coord_reg <= coord_next;
        end
    end

    assign score = score_reg;
    assign coord = coord_reg;

endmodule

`default_nettype wire

### rtl/top_k_score_tracker.sv
// ----------------------------------------------------------------------------
// top_k_score_tracker
// Sorted list of the best scores with their 3-D coordinates, built as a chain
// of insertion cells.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its output is not stalled and
// returns exactly one result item for each, in the cycle after acceptance. The offered score is broadcast to a
// row of LIST_LEN cells; every cell compares it against its own entry in the
// same cycle, the hit flag ripples down the row, and each cell either keeps
// its entry, takes the candidate, or takes its left neighbor's entry. A read
// selects one cell by rank; a clear loads every cell at once. The single
// output register sets the rate: a new item is accepted in any cycle in which
// the output register is empty or its item is being taken. Configuration
// writes are always ready and take effect on the next item; changing the mode
// does not reorder the list.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module top_k_score_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] cand_score, [47:32] cand_x, [63:48] cand_y, [79:64] cand_z,
    // [85:80] read_rank, [87:86] zero
    input  wire logic [87:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_tuser,
    // result item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] taken, [7:1] taken_rank, [39:8] out_score, [55:40] out_x,
    // [71:56] out_y, [87:72] out_z
    output logic [87:0]      m_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int L  = tkst_pkg::LIST_LEN;
    localparam int CB = tkst_pkg::COORD_BITS;

    // ---- configuration registers ------------------------------------------
    logic             keep_smallest_reg;
    tkst_pkg::score_t fill_score_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_smallest_reg <= 1'b0;
            fill_score_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tkst_pkg::REG_KEEP_SMALLEST: keep_smallest_reg <= cfg_data[0];
                tkst_pkg::REG_FILL_SCORE:    fill_score_reg    <= cfg_data;
                default:                     keep_smallest_reg <= keep_smallest_reg;
            endcase
        end
    end

    // ---- input unpacking ---------------------------------------------------
    logic                           accept;
    logic [tkst_pkg::OP_W-1:0]      opcode;
    tkst_pkg::score_t               cand_score;
    logic [tkst_pkg::FIELD_W-1:0]   cand_x;
    logic [tkst_pkg::FIELD_W-1:0]   cand_y;
    logic [tkst_pkg::FIELD_W-1:0]   cand_z;
    logic [tkst_pkg::RRANK_W-1:0]   read_rank;

    assign opcode     = s_tuser;
    assign cand_score = s_tdata[31:0];
    assign cand_x     = s_tdata[47:32];
    assign cand_y     = s_tdata[63:48];
    assign cand_z     = s_tdata[79:64];
    assign read_rank  = s_tdata[85:80];

    logic out_valid_reg;

    // take a new item whenever the output register frees up this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // ---- cell chain --------------------------------------------------------
    tkst_pkg::cell_cmd_t cmd;
    logic               hit   [L+1];
    logic [L-1:0]       first;
    tkst_pkg::score_t   cell_score [L];
    tkst_pkg::coord_t   cell_coord [L];
    tkst_pkg::score_t   prev_score [L];
    tkst_pkg::coord_t   prev_coord [L];

    always_comb
    begin
        cmd.offer         = accept && (opcode == tkst_pkg::OP_OFFER);
        cmd.clear         = accept && (opcode == tkst_pkg::OP_CLEAR);
        cmd.keep_smallest = keep_smallest_reg;
        cmd.fill_score    = fill_score_reg;
        cmd.cand_score    = cand_score;
        // keep only COORD_BITS of each coordinate, x lowest
        cmd.cand_coord    = {CB'(cand_z), CB'(cand_y), CB'(cand_x)};
    end

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < L; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_score[gi] = cand_score;
                assign prev_coord[gi] = cmd.cand_coord;
            end
            else
            begin : g_body
                assign prev_score[gi] = cell_score[gi-1];
                assign prev_coord[gi] = cell_coord[gi-1];
            end

            tkst_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .hit_in     (hit[gi]),
                .prev_score (prev_score[gi]),
                .prev_coord (prev_coord[gi]),
                .hit_out    (hit[gi+1]),
                .first_hit  (first[gi]),
                .score      (cell_score[gi]),
                .coord      (cell_coord[gi])
            );
        end
    endgenerate

    // ---- result forming ----------------------------------------------------
    logic [tkst_pkg::IDX_W-1:0]   taken_idx;
    logic                         taken;
    logic [tkst_pkg::TRANK_W-1:0] taken_rank;
    logic                         rank_ok;
    logic [tkst_pkg::IDX_W-1:0]   read_idx;
    tkst_pkg::coord_t             read_coord;
    logic [tkst_pkg::DATA_W-1:0]  result;

    // encode the one cell that took the candidate
    always_comb
    begin
        taken_idx = '0;
        for (int i = 0; i < L; i++)
        begin
            if (first[i])
            begin
                taken_idx = taken_idx | tkst_pkg::IDX_W'(i);
            end
        end
    end

    assign taken      = hit[L];
    assign taken_rank = taken ? tkst_pkg::TRANK_W'(taken_idx) : tkst_pkg::TRANK_W'(L);
    assign rank_ok    = {1'b0, read_rank} < tkst_pkg::TRANK_W'(L);
    assign read_idx   = read_rank[tkst_pkg::IDX_W-1:0];
    assign read_coord = cell_coord[read_idx];

    always_comb
    begin
        result = '0;
        unique case (opcode)
            tkst_pkg::OP_OFFER:
            begin
                result[0]   = taken;
                result[7:1] = taken_rank;
            end
            tkst_pkg::OP_READ:
            begin
                if (rank_ok)
                begin
                    result[39:8]  = cell_score[read_idx];
                    result[55:40] = 16'(read_coord[CB-1:0]);
                    result[71:56] = 16'(read_coord[2*CB-1:CB]);
                    result[87:72] = 16'(read_coord[3*CB-1:2*CB]);
                end
            end
            tkst_pkg::OP_CLEAR,
            tkst_pkg::OP_NONE:
            begin
                result = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // ---- output register ---------------------------------------------------
    logic                        out_valid_next;
    logic [tkst_pkg::DATA_W-1:0] out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload while the result waits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---- assertions --------------------------------------------------------
    `ASSERT_CLK(a_first_unique, $onehot0(first), "more than one cell took the candidate")

    `ASSERT_CLK(a_taken_rank, (m_tvalid && m_tdata[0]) |-> (m_tdata[7:1] < tkst_pkg::TRANK_W'(L)), "taken item reports a rank past the list end")

    `ASSERT_CLK(a_insert, (cmd.offer && taken) |=> (cell_score[$past(taken_idx)] == $past(cand_score)), "candidate not found at its reported rank")

    `ASSERT_CLK(a_clear, cmd.clear |=> (cell_score[0] == $past(fill_score_reg) && cell_coord[0] == '0), "clear did not load the fill value")

endmodule

`default_nettype wire
